// ----- hdl/fuzz_column_shader_core_defines.svh -----
// Assertion macros shared by the fuzz column shader checker.
`ifndef FUZZ_COLUMN_SHADER_CORE_DEFINES_SVH
`define FUZZ_COLUMN_SHADER_CORE_DEFINES_SVH

// same-cycle implication
`define FCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcs assertion failed");

// next-cycle implication
`define FCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcs assertion failed");

`endif

// ----- hdl/fcs_pkg.sv -----
// Types and constants of the fuzz column shader.
package fcs_pkg;

    localparam int COLOR_W  = 8;
    localparam int ROW_W    = 8;
    localparam int COORD_W  = 10;
    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_COLUMN = 2'd1;
    localparam logic [1:0] REQ_PIXEL  = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_PIXEL  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_DETAIL  = 1'd1;

    localparam logic [ROW_W-1:0] VIEW_HEIGHT_RST = 8'd168;

    localparam int PATTERN_LENGTH = 50;
    localparam int POS_W = 6;
    // 1 = take the pixel below, 0 = the pixel above; entry 0 is leftmost
    localparam logic [0:PATTERN_LENGTH-1] SHADE_ROM =
        50'b1010110_1101110_1110000_1001111_0101100_1100001_1110110_1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [ROW_W-1:0] row;
        logic             wide;
        logic             done;
    } t_s1;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [COLOR_W-1:0]  wdata;
        logic [STORE_AW-1:0] addr_l;
        logic [STORE_AW-1:0] addr_r;
    } t_ram_ctl;

endpackage

// ----- hdl/fcs_in_if.sv -----
// Input item channel of the fuzz column shader.
interface fcs_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic [fcs_pkg::STORE_AW-1:0]        map_index;
    logic [fcs_pkg::COLOR_W-1:0]         map_value;
    logic [fcs_pkg::COORD_W-1:0]         col_x;
    logic signed [fcs_pkg::COORD_W-1:0]  top_row;
    logic signed [fcs_pkg::COORD_W-1:0]  bottom_row;
    logic [fcs_pkg::COLOR_W-1:0]         above_left;
    logic [fcs_pkg::COLOR_W-1:0]         below_left;
    logic [fcs_pkg::COLOR_W-1:0]         above_right;
    logic [fcs_pkg::COLOR_W-1:0]         below_right;

    modport source (output valid, req_type, map_index, map_value, col_x, top_row,
                    bottom_row, above_left, below_left, above_right, below_right,
                    input ready);
    modport sink   (input valid, req_type, map_index, map_value, col_x, top_row,
                    bottom_row, above_left, below_left, above_right, below_right,
                    output ready);
endinterface

// ----- hdl/fcs_out_if.sv -----
// Result item channel of the fuzz column shader.
interface fcs_out_if #(
    parameter int XW = 9
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   result_kind;
    logic [1:0]                   column_status;
    logic [XW-1:0]                write_x;
    logic [fcs_pkg::ROW_W-1:0]    write_row;
    logic [fcs_pkg::COLOR_W-1:0]  color_left;
    logic [fcs_pkg::COLOR_W-1:0]  color_right;
    logic                         two_wide;
    logic                         column_done;

    modport source (output valid, result_kind, column_status, write_x, write_row,
                    color_left, color_right, two_wide, column_done, input ready);
    modport sink   (input valid, result_kind, column_status, write_x, write_row,
                    color_left, color_right, two_wide, column_done, output ready);
endinterface

// ----- hdl/fcs_cfg_if.sv -----
// Configuration write channel of the fuzz column shader.
interface fcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fcs_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [fcs_pkg::CFG_DATA_W-1:0]    wr_data;

    modport source (output valid, reg_idx, wr_data, input ready);
    modport sink   (input valid, reg_idx, wr_data, output ready);
endinterface

// ----- hdl/fcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fcs_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fcs_ctrl.sv -----
// Column state, configuration registers and per-item decode.
module fcs_ctrl #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int XW            = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [1:0]                          i_req_type,
    input  logic [fcs_pkg::STORE_AW-1:0]        i_map_index,
    input  logic [fcs_pkg::COLOR_W-1:0]         i_map_value,
    input  logic [fcs_pkg::COORD_W-1:0]         i_col_x,
    input  logic signed [fcs_pkg::COORD_W-1:0]  i_top_row,
    input  logic signed [fcs_pkg::COORD_W-1:0]  i_bottom_row,
    input  logic [fcs_pkg::COLOR_W-1:0]         i_above_left,
    input  logic [fcs_pkg::COLOR_W-1:0]         i_below_left,
    input  logic [fcs_pkg::COLOR_W-1:0]         i_above_right,
    input  logic [fcs_pkg::COLOR_W-1:0]         i_below_right,
    input  logic                                i_cfg_we,
    input  logic [fcs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fcs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output fcs_pkg::t_s1                        o_s1,
    output logic [XW-1:0]                       o_x,
    output fcs_pkg::t_ram_ctl                   o_ram
);

    localparam logic [10:0]        SW_L = 11'(SCREEN_WIDTH);
    localparam logic signed [11:0] SH_L = 12'(SCREEN_HEIGHT);

    logic                            r_active, n_active;
    logic [fcs_pkg::ROW_W-1:0]       r_row, n_row;
    logic [fcs_pkg::ROW_W-1:0]       r_end, n_end;
    logic [XW-1:0]                   r_x, n_x;
    logic                            r_wide, n_wide;
    logic [fcs_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [fcs_pkg::ROW_W-1:0]       r_view_height;
    logic                            r_low_detail;

    logic [10:0]        x_full;
    logic signed [11:0] top_s, bot_s, lim, top_c, bot_c;
    logic               below;

    always_comb begin
        x_full = r_low_detail ? {i_col_x, 1'b0} : {1'b0, i_col_x};
        top_s  = $signed({{2{i_top_row[9]}}, i_top_row});
        bot_s  = $signed({{2{i_bottom_row[9]}}, i_bottom_row});
        lim    = $signed({4'b0000, r_view_height}) - 12'sd2;
        top_c  = (top_s < 12'sd1) ? 12'sd1 : top_s;
        bot_c  = (bot_s > lim) ? lim : bot_s;
        below  = fcs_pkg::SHADE_ROM[r_pos];

        n_active = r_active;
        n_row    = r_row;
        n_end    = r_end;
        n_x      = r_x;
        n_wide   = r_wide;
        n_pos    = r_pos;

        o_s1 = '0;
        o_x  = '0;
        o_ram.we     = 1'b0;
        o_ram.waddr  = i_map_index;
        o_ram.wdata  = i_map_value;
        o_ram.addr_l = below ? i_below_left : i_above_left;
        o_ram.addr_r = below ? i_below_right : i_above_right;

        unique case (i_req_type)
            fcs_pkg::REQ_LOAD: begin
                o_ram.we = 1'b1;
            end
            fcs_pkg::REQ_COLUMN: begin
                n_active  = 1'b0;
                o_s1.kind = fcs_pkg::KIND_STATUS;
                if (bot_s < top_s) begin
                    o_s1.status = fcs_pkg::ST_EMPTY;
                end else if (x_full >= SW_L || top_s < 12'sd0 || bot_s >= SH_L) begin
                    o_s1.status = fcs_pkg::ST_RANGE;
                end else begin
                    o_s1.status = fcs_pkg::ST_OK;
                    if (top_c <= bot_c) begin
                        n_active = 1'b1;
                        n_row    = top_c[fcs_pkg::ROW_W-1:0];
                        n_end    = bot_c[fcs_pkg::ROW_W-1:0];
                        n_x      = x_full[XW-1:0];
                        n_wide   = r_low_detail;
                    end
                end
            end
            fcs_pkg::REQ_PIXEL: begin
                if (r_active) begin
                    o_s1.kind = fcs_pkg::KIND_PIXEL;
                    o_s1.row  = r_row;
                    o_s1.wide = r_wide;
                    o_s1.done = (r_row == r_end);
                    o_x       = r_x;
                    if (r_row == r_end) begin
                        n_active = 1'b0;
                    end else begin
                        n_row = r_row + 8'd1;
                    end
                    n_pos = (r_pos == fcs_pkg::POS_W'(fcs_pkg::PATTERN_LENGTH - 1)) ?
                            '0 : r_pos + 6'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_row         <= '0;
            r_end         <= '0;
            r_x           <= '0;
            r_wide        <= 1'b0;
            r_pos         <= '0;
            r_view_height <= fcs_pkg::VIEW_HEIGHT_RST;
            r_low_detail  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_active <= n_active;
                r_row    <= n_row;
                r_end    <= n_end;
                r_x      <= n_x;
                r_wide   <= n_wide;
                r_pos    <= n_pos;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fcs_pkg::REG_VIEW_HEIGHT: r_view_height <= i_cfg_data;
                    fcs_pkg::REG_LOW_DETAIL:  r_low_detail  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- hdl/fuzz_column_shader_core.sv -----
// Top level of the fuzz column shader: decode, colour store and output stage.
// Takes one item per clock when the output is drained and returns exactly one result
// beat per item: the decode result and the registered colour store read are held in
// the first register stage, then the output register takes them. Two items can be
// held while the output is stalled. The colour store is kept as two identical 256x8
// RAM copies so both pixels of a low-detail row are translated in the same read cycle.
// Configuration writes are always accepted and take effect on the next item.
module fuzz_column_shader_core #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fcs_in_if.sink         i_in,
    fcs_out_if.source      o_out,
    fcs_cfg_if.sink        i_cfg
);

    localparam int XW = $clog2(SCREEN_WIDTH);

    logic                          accept_in;
    logic                          s1_adv;
    fcs_pkg::t_s1                  s1_d;
    logic [XW-1:0]                 x_d;
    fcs_pkg::t_ram_ctl             ram;
    logic [fcs_pkg::COLOR_W-1:0]   rd_l, rd_r;

    logic                          r_v1, r_v2;
    fcs_pkg::t_s1                  r_s1, r_out;
    logic [XW-1:0]                 r_x1, r_out_x;
    logic [fcs_pkg::COLOR_W-1:0]   r_out_cl, r_out_cr;

    assign s1_adv     = r_v1 && (!r_v2 || o_out.ready);
    assign i_in.ready = !r_v1 || s1_adv;
    assign accept_in  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    fcs_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .XW            (XW)
    ) u_fcs_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept_in),
        .i_req_type    (i_in.req_type),
        .i_map_index   (i_in.map_index),
        .i_map_value   (i_in.map_value),
        .i_col_x       (i_in.col_x),
        .i_top_row     (i_in.top_row),
        .i_bottom_row  (i_in.bottom_row),
        .i_above_left  (i_in.above_left),
        .i_below_left  (i_in.below_left),
        .i_above_right (i_in.above_right),
        .i_below_right (i_in.below_right),
        .i_cfg_we      (i_cfg.valid && i_cfg.ready),
        .i_cfg_idx     (i_cfg.reg_idx),
        .i_cfg_data    (i_cfg.wr_data),
        .o_s1          (s1_d),
        .o_x           (x_d),
        .o_ram         (ram)
    );

    fcs_ram #(
        .W     (fcs_pkg::COLOR_W),
        .DEPTH (fcs_pkg::STORE_DEPTH)
    ) u_fcs_ram_l (
        .i_clk   (i_clk),
        .i_we    (accept_in && ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (accept_in),
        .i_raddr (ram.addr_l),
        .o_rdata (rd_l)
    );

    fcs_ram #(
        .W     (fcs_pkg::COLOR_W),
        .DEPTH (fcs_pkg::STORE_DEPTH)
    ) u_fcs_ram_r (
        .i_clk   (i_clk),
        .i_we    (accept_in && ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (accept_in),
        .i_raddr (ram.addr_r),
        .o_rdata (rd_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (accept_in) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end
            if (s1_adv) begin
                r_v2 <= 1'b1;
            end else if (o_out.ready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1 <= s1_d;
            r_x1 <= x_d;
        end
        if (s1_adv) begin
            r_out    <= r_s1;
            r_out_x  <= r_x1;
            r_out_cl <= (r_s1.kind == fcs_pkg::KIND_PIXEL) ? rd_l : '0;
            r_out_cr <= (r_s1.kind == fcs_pkg::KIND_PIXEL && r_s1.wide) ? rd_r : '0;
        end
    end

    assign o_out.valid         = r_v2;
    assign o_out.result_kind   = r_out.kind;
    assign o_out.column_status = r_out.status;
    assign o_out.write_x       = r_out_x;
    assign o_out.write_row     = r_out.row;
    assign o_out.color_left    = r_out_cl;
    assign o_out.color_right   = r_out_cr;
    assign o_out.two_wide      = r_out.wide;
    assign o_out.column_done   = r_out.done;

endmodule

// ----- hdl/fcs_checker.sv -----
// Port-level checker for the fuzz column shader, bound to the top level.
`include "fuzz_column_shader_core_defines.svh"

module fcs_checker #(
    parameter int XW = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_kind,
    input  logic [1:0]                    i_status,
    input  logic [XW-1:0]                 i_x,
    input  logic [fcs_pkg::ROW_W-1:0]     i_row,
    input  logic [fcs_pkg::COLOR_W-1:0]   i_cl,
    input  logic [fcs_pkg::COLOR_W-1:0]   i_cr,
    input  logic                          i_wide,
    input  logic                          i_done
);

    `FCS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable({i_kind, i_status, i_x, i_row, i_cl, i_cr, i_wide, i_done}))

    // clamped columns never write the top row
    `FCS_ASSERT_IMP(a_pixel_row, i_clk, i_rst_n,
        i_out_valid && i_kind == fcs_pkg::KIND_PIXEL, i_row != '0)

    `FCS_ASSERT_IMP(a_nonpixel_zero, i_clk, i_rst_n,
        i_out_valid && i_kind != fcs_pkg::KIND_PIXEL,
        i_cl == '0 && i_cr == '0 && !i_wide && !i_done && i_x == '0 && i_row == '0)

    `FCS_ASSERT_IMP(a_status_only, i_clk, i_rst_n,
        i_out_valid && i_kind != fcs_pkg::KIND_STATUS, i_status == fcs_pkg::ST_OK)

endmodule

bind fuzz_column_shader_core fcs_checker #(
    .XW (XW)
) u_fcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.result_kind),
    .i_status    (o_out.column_status),
    .i_x         (o_out.write_x),
    .i_row       (o_out.write_row),
    .i_cl        (o_out.color_left),
    .i_cr        (o_out.color_right),
    .i_wide      (o_out.two_wide),
    .i_done      (o_out.column_done)
);
